// File: hw/rtl/quoted_argument_tokenizer_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quoted argument tokenizer
// Two property forms: same-cycle implication and next-cycle implication.
// ----------------------------------------------------------------------------
`ifndef QUOTED_ARGUMENT_TOKENIZER_UNIT_ASSERT_SVH
`define QUOTED_ARGUMENT_TOKENIZER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define QAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define QAT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define QAT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/qat_pkg.sv
// ----------------------------------------------------------------------------
// qat_pkg
// Types and constants shared by the quoted argument tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package qat_pkg;

	typedef enum logic [1:0] {
		K_BYTE = 2'd0,
		K_WEND = 2'd1,
		K_LEND = 2'd2,
		K_MANY = 2'd3
	} kind_t;

	localparam int RES_MAX = 4;

	localparam logic [7:0] LIMIT_CAP   = 8'd128;
	localparam logic [7:0] LIMIT_RESET = 8'd128;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HT     = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	typedef logic [2:0] res_cnt_t;
	typedef logic [1:0] res_ptr_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] ch;
		logic [6:0] idx;
		logic [6:0] cnt;
		logic       last;
	} result_t;

	typedef struct packed {
		result_t [RES_MAX-1:0] res;
		res_cnt_t              n;
	} batch_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_HT) && (c <= CH_CR));
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/qat_if.sv
// ----------------------------------------------------------------------------
// qat_in_if / qat_out_if
// Valid/ready channels for line bytes in and token results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface qat_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       line_last;

	modport source (output valid, output char_in, output line_last, input ready);
	modport sink   (input valid, input char_in, input line_last, output ready);
endinterface

interface qat_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] char_out;
	logic [6:0] word_index;
	logic [6:0] word_count;
	logic       run_last;

	modport source (output valid, output kind, output char_out, output word_index,
		output word_count, output run_last, input ready);
	modport sink   (input valid, input kind, input char_out, input word_index,
		input word_count, input run_last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qat_core.sv
// ----------------------------------------------------------------------------
// qat_core
// Input register, line parse state and the per-byte step that builds the
// list of results for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_core import qat_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	qat_in_if.sink          chars,
	input  wire logic [7:0] word_limit,
	input  wire logic       take,
	output batch_t          batch,
	output logic            batch_valid
);

	logic [7:0] char_s1;
	logic       last_s1;
	logic       valid_s1;

	logic       in_word_q;
	logic       in_quotes_q;
	logic       quote_double_q;
	logic       bs_held_q;
	logic [6:0] words_seen_q;
	logic       overflowed_q;

	logic       in_word_d;
	logic       in_quotes_d;
	logic       quote_double_d;
	logic       bs_held_d;
	logic [6:0] words_seen_d;
	logic       overflowed_d;

	logic       advance;
	batch_t     b;

	function automatic batch_t add_res(input batch_t bi, input kind_t k,
		input logic [7:0] c, input logic [6:0] idx, input logic [6:0] ws);
		batch_t bo;
		bo = bi;
		bo.res[bi.n[1:0]].kind = k;
		bo.res[bi.n[1:0]].ch   = c;
		bo.res[bi.n[1:0]].idx  = idx;
		bo.res[bi.n[1:0]].cnt  = ws;
		bo.res[bi.n[1:0]].last = 1'b0;
		bo.n = bi.n + 3'd1;
		return bo;
	endfunction

	function automatic logic [6:0] cur_idx(input logic [6:0] ws);
		return (ws != 7'd0) ? (ws - 7'd1) : 7'd0;
	endfunction

	assign advance     = valid_s1 && take;
	assign chars.ready = !valid_s1 || take;
	assign batch_valid = valid_s1;
	assign batch       = b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
			last_s1 <= chars.line_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q      <= 1'b0;
			in_quotes_q    <= 1'b0;
			quote_double_q <= 1'b0;
			bs_held_q      <= 1'b0;
			words_seen_q   <= '0;
			overflowed_q   <= 1'b0;
		end else if (advance) begin
			in_word_q      <= in_word_d;
			in_quotes_q    <= in_quotes_d;
			quote_double_q <= quote_double_d;
			bs_held_q      <= bs_held_d;
			words_seen_q   <= words_seen_d;
			overflowed_q   <= overflowed_d;
		end
	end

	always_comb begin
		logic [7:0] lim;
		logic [7:0] c;
		logic       done;
		logic       c_ws;
		logic       c_quote;

		c       = char_s1;
		c_ws    = is_ws(c);
		c_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);
		done    = 1'b0;

		priority if (word_limit > LIMIT_CAP) begin
			lim = LIMIT_CAP;
		end else if (word_limit == 8'd0) begin
			lim = 8'd1;
		end else begin
			lim = word_limit;
		end

		in_word_d      = in_word_q;
		in_quotes_d    = in_quotes_q;
		quote_double_d = quote_double_q;
		bs_held_d      = bs_held_q;
		words_seen_d   = words_seen_q;
		overflowed_d   = overflowed_q;
		b              = '0;

		if (!overflowed_q) begin
			if (bs_held_q) begin
				bs_held_d = 1'b0;
				if (in_quotes_q) begin
					if ((c == CH_DQUOTE) || (c == CH_BSLASH)) begin
						b    = add_res(b, K_BYTE, c, cur_idx(words_seen_d), words_seen_d);
						done = 1'b1;
					end else begin
						b = add_res(b, K_BYTE, CH_BSLASH, cur_idx(words_seen_d),
							words_seen_d);
					end
				end else begin
					if (!(c_ws || c_quote || (c == CH_BSLASH))) begin
						b = add_res(b, K_BYTE, CH_BSLASH, cur_idx(words_seen_d),
							words_seen_d);
					end
					b    = add_res(b, K_BYTE, c, cur_idx(words_seen_d), words_seen_d);
					done = 1'b1;
				end
			end

			if (!done && !in_word_d) begin
				if (c_ws) begin
					done = 1'b1;
				end else if (({1'b0, words_seen_d} + 8'd1) >= lim) begin
					overflowed_d = 1'b1;
					b    = add_res(b, K_MANY, 8'd0, 7'd0, words_seen_d);
					done = 1'b1;
				end else begin
					words_seen_d = words_seen_d + 7'd1;
					in_word_d    = 1'b1;
				end
			end

			if (!done) begin
				if (in_quotes_d) begin
					if (c == (quote_double_d ? CH_DQUOTE : CH_SQUOTE)) begin
						in_quotes_d = 1'b0;
					end else if (quote_double_d && (c == CH_BSLASH)) begin
						bs_held_d = 1'b1;
					end else begin
						b = add_res(b, K_BYTE, c, cur_idx(words_seen_d), words_seen_d);
					end
				end else if (c_quote) begin
					in_quotes_d    = 1'b1;
					quote_double_d = (c == CH_DQUOTE);
				end else if (c_ws) begin
					b = add_res(b, K_WEND, 8'd0, cur_idx(words_seen_d), words_seen_d);
					in_word_d = 1'b0;
				end else if (c == CH_BSLASH) begin
					bs_held_d = 1'b1;
				end else begin
					b = add_res(b, K_BYTE, c, cur_idx(words_seen_d), words_seen_d);
				end
			end
		end

		if (last_s1) begin
			if (bs_held_d) begin
				b = add_res(b, K_BYTE, CH_BSLASH, cur_idx(words_seen_d), words_seen_d);
			end
			if (in_word_d) begin
				b = add_res(b, K_WEND, 8'd0, cur_idx(words_seen_d), words_seen_d);
			end
			b = add_res(b, K_LEND, 8'd0, 7'd0, words_seen_d);
			in_word_d      = 1'b0;
			in_quotes_d    = 1'b0;
			quote_double_d = 1'b0;
			bs_held_d      = 1'b0;
			words_seen_d   = '0;
			overflowed_d   = 1'b0;
		end

		if (b.n != 3'd0) begin
			b.res[b.n[1:0] - 2'd1].last = 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/qat_obuf.sv
// ----------------------------------------------------------------------------
// qat_obuf
// Result register for one byte's results, shown one per cycle while ready.
// ----------------------------------------------------------------------------
`default_nettype none

module qat_obuf import qat_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire batch_t batch,
	input  wire logic   batch_valid,
	output logic        take,
	qat_out_if.source   tokens
);

	result_t [RES_MAX-1:0] res_q;
	res_cnt_t              cnt_q;
	res_ptr_t              ptr_q;
	result_t               cur;

	assign take = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && tokens.ready);
	assign cur  = res_q[ptr_q];

	assign tokens.valid      = (cnt_q != 3'd0);
	assign tokens.kind       = cur.kind;
	assign tokens.char_out   = cur.ch;
	assign tokens.word_index = cur.idx;
	assign tokens.word_count = cur.cnt;
	assign tokens.run_last   = cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else if (batch_valid && take) begin
			cnt_q <= batch.n;
			ptr_q <= '0;
		end else if (tokens.valid && tokens.ready) begin
			cnt_q <= cnt_q - 3'd1;
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (batch_valid && take) begin
			res_q <= batch.res;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/quoted_argument_tokenizer_unit.sv
// A byte passes the core input register, then the single result register.
// Throughput: one byte per cycle while the output is ready and each byte
// gives at most one result; a byte with k results holds the result register
// for k output transfers; that register and its drain counter set the rate.
// Reset clears the parse state and all valid flags; word_limit returns to 128.
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_unit
// Splits a command line, one byte per transfer, into quoted words.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quoted_argument_tokenizer_unit_assert.svh"

module quoted_argument_tokenizer_unit import qat_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	qat_in_if.sink          chars,
	qat_out_if.source       tokens,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	logic [7:0] word_limit_q;
	logic       take;
	logic       batch_valid;
	batch_t     batch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			word_limit_q <= cfg_wdata;
		end
	end

	qat_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.chars       (chars),
		.word_limit  (word_limit_q),
		.take        (take),
		.batch       (batch),
		.batch_valid (batch_valid)
	);

	qat_obuf u_obuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.batch       (batch),
		.batch_valid (batch_valid),
		.take        (take),
		.tokens      (tokens)
	);

	`QAT_ASSERT_IMPL(a_lend_is_last, clk, arst_n,
		tokens.valid && (tokens.kind == K_LEND), tokens.run_last)
	`QAT_ASSERT_IMPL(a_nonbyte_zero, clk, arst_n,
		tokens.valid && (tokens.kind != K_BYTE), tokens.char_out == 8'd0)
	`QAT_ASSERT_IMPL(a_index_count, clk, arst_n,
		tokens.valid && ((tokens.kind == K_BYTE) || (tokens.kind == K_WEND)),
		(tokens.word_count != 7'd0) && (tokens.word_index == tokens.word_count - 7'd1))
	`QAT_ASSERT_NEXT(a_run_continues, clk, arst_n,
		tokens.valid && tokens.ready && !tokens.run_last, tokens.valid)

endmodule

`default_nettype wire
